@@ hdl/pls_pkg.sv @@
package pls_pkg;

    // Request operation codes
    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_GET    = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    // Response status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Fixed field widths of the request and response transactions
    localparam int unsigned POS_W   = 8;
    localparam int unsigned DIN_W   = 32;
    localparam int unsigned DOUT_W  = 32;
    localparam int unsigned COUNT_W = 6;

    // Control broadcast from the top level to every cell
    typedef struct packed {
        logic             ins;  // shift right from at, load new entry at at
        logic             del;  // shift left from at
        logic [POS_W-1:0] at;   // target cell, also the read select
    } t_cell_ctl;

endpackage

@@ hdl/pls_if.sv @@
interface pls_req_if;
    logic                                valid;
    logic                                ready;
    pls_pkg::t_mode                      mode;
    logic [pls_pkg::POS_W-1:0]           position;
    logic [pls_pkg::DIN_W-1:0]           data_in;
    logic                                owned;

    modport source (output valid, mode, position, data_in, owned, input ready);
    modport sink   (input valid, mode, position, data_in, owned, output ready);
endinterface

interface pls_rsp_if;
    logic                                valid;
    logic                                ready;
    pls_pkg::t_status                    status;
    logic [pls_pkg::DOUT_W-1:0]          data_out;
    logic [pls_pkg::COUNT_W-1:0]         count;

    modport source (output valid, status, data_out, count, input ready);
    modport sink   (input valid, status, data_out, count, output ready);
endinterface

@@ hdl/pls_cell.sv @@
module pls_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  pls_pkg::t_cell_ctl    i_ctl,
    input  logic [DATA_WIDTH-1:0] i_new_data,
    input  logic                  i_new_owned,
    input  logic [DATA_WIDTH-1:0] i_left_data,
    input  logic                  i_left_owned,
    input  logic [DATA_WIDTH-1:0] i_right_data,
    input  logic                  i_right_owned,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_owned,
    output logic [DATA_WIDTH-1:0] o_rd_data,
    output logic                  o_rd_owned
);
    import pls_pkg::*;

    localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_owned;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  n_owned;

    // Pick the next entry: hold, take from a neighbor, or load the new one
    always_comb begin
        n_data  = r_data;
        n_owned = r_owned;
        if (i_ctl.ins) begin
            if (IDX > i_ctl.at) begin
                n_data  = i_left_data;
                n_owned = i_left_owned;
            end else if (IDX == i_ctl.at) begin
                n_data  = i_new_data;
                n_owned = i_new_owned;
            end
        end else if (i_ctl.del && (IDX >= i_ctl.at)) begin
            n_data  = i_right_data;
            n_owned = i_right_owned;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_owned <= n_owned;
    end

    assign o_data  = r_data;
    assign o_owned = r_owned;

    // Drive the read bus only when selected, so the top level can OR them
    assign o_rd_data  = (IDX == i_ctl.at) ? r_data : '0;
    assign o_rd_owned = (IDX == i_ctl.at) ? r_owned : 1'b0;

endmodule

@@ hdl/positional_list_store_core.sv @@
// Positional list store: an ordered list of up to CAPACITY data handles,
// each with an owned flag, kept in a row of cells that shift all at once.
// Request channel (i_req): mode, position, data_in, owned. Insert places a
// handle at position (at or past the count means the tail), delete removes
// the entry at position, get reads it, clear empties the list.
// Response channel (o_rsp): status, data_out, count, one per request.
// The response is registered and valid in the cycle after the request
// transaction. Throughput: one request per cycle while the response
// drains; no operation holds up the next, because the whole cell row
// shifts at once and the read is a one-hot select over the cells.
// Stall: the response register holds while o_rsp.ready is low; a new
// request is taken only when that register is empty or being drained in
// the same cycle, so nothing is lost or repeated.
// Reset: the entry count clears to zero and the response register empties;
// cell contents are not cleared and are only ever read below the count.
module positional_list_store_core #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pls_req_if.sink   i_req,
    pls_rsp_if.source o_rsp
);
    import pls_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

    // Cell row wiring
    logic [DATA_WIDTH-1:0] w_data    [CAPACITY];
    logic                  w_owned   [CAPACITY];
    logic [DATA_WIDTH-1:0] w_rd_data [CAPACITY];
    logic                  w_rd_owned[CAPACITY];

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    t_status               r_status;
    logic [DOUT_W-1:0]     r_data_out;
    logic [COUNT_W-1:0]    r_count_out;

    logic                  w_acc;
    logic [DATA_WIDTH-1:0] w_new_data;
    logic                  w_past_end;
    t_status               w_status;
    logic [DATA_WIDTH-1:0] w_result;
    logic [DATA_WIDTH-1:0] w_sel_data;
    logic                  w_sel_owned;
    t_cell_ctl             w_ctl;

    // Take a request when the response register is free or draining
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_acc       = i_req.valid && i_req.ready;

    assign w_new_data = DATA_WIDTH'(i_req.data_in);
    assign w_past_end = CMP_W'(i_req.position) >= CMP_W'(r_count);

    // Combine the one-hot read buses of all cells
    always_comb begin
        w_sel_data  = '0;
        w_sel_owned = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_sel_data  = w_sel_data | w_rd_data[i];
            w_sel_owned = w_sel_owned | w_rd_owned[i];
        end
    end

    // Decode the request into status, result, next count and cell control
    always_comb begin
        w_status  = ST_OK;
        w_result  = '0;
        n_count   = r_count;
        w_ctl.ins = 1'b0;
        w_ctl.del = 1'b0;
        w_ctl.at  = i_req.position;
        case (i_req.mode)
            MODE_INSERT: begin
                if (w_past_end) begin
                    w_ctl.at = POS_W'(r_count);
                end
                if (w_new_data == '0) begin
                    w_status = ST_ZERO;
                end else if (r_count == CAP) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.ins = w_acc;
                    n_count   = r_count + 1'b1;
                end
            end
            MODE_DELETE: begin
                if (w_past_end) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctl.del = w_acc;
                    w_result  = w_sel_owned ? '0 : w_sel_data;
                    n_count   = r_count - 1'b1;
                end
            end
            MODE_GET: begin
                if (w_past_end) begin
                    w_status = ST_RANGE;
                end else begin
                    w_result = w_sel_data;
                end
            end
            MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Row of cells, each shifting with its neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left_data;
        logic                  w_left_owned;
        logic [DATA_WIDTH-1:0] w_right_data;
        logic                  w_right_owned;

        if (g == 0) begin : g_head
            assign w_left_data  = '0;
            assign w_left_owned = 1'b0;
        end else begin : g_mid_l
            assign w_left_data  = w_data[g-1];
            assign w_left_owned = w_owned[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_data  = '0;
            assign w_right_owned = 1'b0;
        end else begin : g_mid_r
            assign w_right_data  = w_data[g+1];
            assign w_right_owned = w_owned[g+1];
        end

        pls_cell #(
            .DATA_WIDTH(DATA_WIDTH),
            .INDEX     (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_new_data   (w_new_data),
            .i_new_owned  (i_req.owned),
            .i_left_data  (w_left_data),
            .i_left_owned (w_left_owned),
            .i_right_data (w_right_data),
            .i_right_owned(w_right_owned),
            .o_data       (w_data[g]),
            .o_owned      (w_owned[g]),
            .o_rd_data    (w_rd_data[g]),
            .o_rd_owned   (w_rd_owned[g])
        );
    end

    // Hold the count and the response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_acc) begin
            r_status    <= w_status;
            r_data_out  <= DOUT_W'(w_result);
            r_count_out <= COUNT_W'(n_count);
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_status;
    assign o_rsp.data_out = r_data_out;
    assign o_rsp.count    = r_count_out;

    // Count never exceeds the number of cells
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("entry count above capacity");

    // A successful insert grows the list by one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_req.mode == MODE_INSERT && w_status == ST_OK)
        |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the list");

    // A clear empties the list and reports zero
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_req.mode == MODE_CLEAR)
        |=> (r_count == '0) && (r_count_out == '0))
        else $error("clear left entries behind");

    // Rejected requests return no data
    a_reject_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> r_data_out == '0)
        else $error("rejected request returned data");

    // Rejected requests leave the count unchanged
    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_status != ST_OK) |=> $stable(r_count))
        else $error("rejected request changed the count");

endmodule

@@ verif/positional_list_store_core_test.sv @@
module positional_list_store_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pls_pkg::*;

    localparam int CAPACITY   = 32;
    localparam int DATA_WIDTH = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;
    localparam logic [DIN_W-1:0] DATA_MASK = DIN_W'({DATA_WIDTH{1'b1}});

    // One predicted response transaction
    typedef struct {
        t_status              status;
        logic [DOUT_W-1:0]    data;
        logic [COUNT_W-1:0]   count;
    } t_list_rsp;

    // Shadow copy of the list plus the queue of responses it predicts
    class list_response_board;
        logic [DIN_W-1:0]  shadow_data [CAPACITY];
        logic              shadow_owned [CAPACITY];
        int                shadow_count;
        t_list_rsp         pending_rsp [$];
        int                failures;
        int                mode_seen [4];
        int                status_seen [4];

        function new();
            shadow_count = 0;
            failures     = 0;
            foreach (mode_seen[i]) mode_seen[i] = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // Apply one accepted request to the shadow list, queue its response
        function void note_request(t_mode mode, logic [POS_W-1:0] pos,
                                   logic [DIN_W-1:0] data_in, logic owned);
            t_list_rsp         rsp;
            logic [DIN_W-1:0]  handle;
            int                at;
            int                p;
            handle   = data_in & DATA_MASK;
            p        = int'(pos);
            rsp.status = ST_OK;
            rsp.data   = '0;
            case (mode)
                MODE_INSERT: begin
                    if (handle == '0) begin
                        rsp.status = ST_ZERO;
                    end else if (shadow_count >= CAPACITY) begin
                        rsp.status = ST_FULL;
                    end else begin
                        at = (p >= shadow_count) ? shadow_count : p;
                        for (int i = shadow_count; i > at; i--) begin
                            shadow_data[i]  = shadow_data[i-1];
                            shadow_owned[i] = shadow_owned[i-1];
                        end
                        shadow_data[at]  = handle;
                        shadow_owned[at] = owned;
                        shadow_count++;
                    end
                end
                MODE_DELETE: begin
                    if (p >= shadow_count) begin
                        rsp.status = ST_RANGE;
                    end else begin
                        rsp.data = shadow_owned[p] ? '0 : shadow_data[p];
                        for (int i = p; i + 1 < shadow_count; i++) begin
                            shadow_data[i]  = shadow_data[i+1];
                            shadow_owned[i] = shadow_owned[i+1];
                        end
                        shadow_count--;
                    end
                end
                MODE_GET: begin
                    if (p >= shadow_count) rsp.status = ST_RANGE;
                    else rsp.data = shadow_data[p];
                end
                default: begin
                    shadow_count = 0;
                end
            endcase
            rsp.count = COUNT_W'(shadow_count);
            mode_seen[mode]++;
            status_seen[rsp.status]++;
            pending_rsp.push_back(rsp);
        endfunction

        // Compare one accepted response with the oldest prediction
        function void check_response(t_status status, logic [DOUT_W-1:0] data,
                                     logic [COUNT_W-1:0] count);
            t_list_rsp exp_rsp;
            if (pending_rsp.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected response: status %0d data %h count %0d",
                             status, data, count);
                return;
            end
            exp_rsp = pending_rsp.pop_front();
            if (status !== exp_rsp.status || data !== exp_rsp.data ||
                count !== exp_rsp.count) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("mismatch: expected status %0d data %h count %0d, %s %0d %h %0d",
                             exp_rsp.status, exp_rsp.data, exp_rsp.count,
                             "got", status, data, count);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    bit   gaps_on;

    pls_req_if req_ch ();
    pls_rsp_if rsp_ch ();

    list_response_board board;

    positional_list_store_core #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Clock: 2 ns period
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Abort a hung run
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Check accepted responses and apply random backpressure
    int stall_left;
    initial stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_response(rsp_ch.status, rsp_ch.data_out, rsp_ch.count);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Send one request and hold it until the transaction completes
    task automatic send_req(t_mode mode, logic [POS_W-1:0] pos,
                            logic [DIN_W-1:0] data_in, logic owned);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.mode     <= mode;
        req_ch.position <= pos;
        req_ch.data_in  <= data_in;
        req_ch.owned    <= owned;
        do @(posedge i_clk); while (!req_ch.ready);
        board.note_request(mode, pos, data_in, owned);
    endtask

    // Random handle: mostly wide random, sometimes zero, all ones or one bit
    function automatic logic [DIN_W-1:0] pick_handle();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0:       return '0;
            1:       return '1;
            2:       return DIN_W'(1) << $urandom_range(0, DIN_W - 1);
            default: return DIN_W'($urandom);
        endcase
    endfunction

    // Random requests with the given mix in percent; the rest are clears
    task automatic run_phase(int n, int w_ins, int w_del, int w_get);
        int                r;
        t_mode             mode;
        logic [POS_W-1:0]  pos;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < w_ins) mode = MODE_INSERT;
            else if (r < w_ins + w_del) mode = MODE_DELETE;
            else if (r < w_ins + w_del + w_get) mode = MODE_GET;
            else mode = MODE_CLEAR;
            if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 255));
            else pos = POS_W'($urandom_range(0, board.shadow_count + 1));
            send_req(mode, pos, pick_handle(), 1'($urandom));
        end
    endtask

    initial begin
        board   = new();
        gaps_on = 1'b1;
        i_rst_n = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.mode     = MODE_INSERT;
        req_ch.position = '0;
        req_ch.data_in  = '0;
        req_ch.owned    = 1'b0;
        rsp_ch.ready    = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-list corners, zero handle, head/middle/tail, owned delete
        send_req(MODE_CLEAR,  8'd0,   32'h0,          1'b0);
        send_req(MODE_GET,    8'd0,   32'h0,          1'b0);
        send_req(MODE_DELETE, 8'd255, 32'h0,          1'b0);
        send_req(MODE_INSERT, 8'd0,   32'h0,          1'b0);
        send_req(MODE_INSERT, 8'd255, 32'hFFFF_FFFF,  1'b0);
        send_req(MODE_DELETE, 8'd0,   32'h0,          1'b0);
        send_req(MODE_INSERT, 8'd200, 32'h0000_0001,  1'b1);
        send_req(MODE_INSERT, 8'd0,   32'h8000_0000,  1'b0);
        send_req(MODE_INSERT, 8'd1,   32'h1234_5678,  1'b1);
        send_req(MODE_INSERT, 8'd3,   32'hA5A5_A5A5,  1'b0);
        for (int i = 0; i <= 4; i++)
            send_req(MODE_GET, POS_W'(i), 32'h0, 1'b0);
        send_req(MODE_DELETE, 8'd1,   32'h0,          1'b0);
        send_req(MODE_DELETE, 8'd3,   32'h0,          1'b0);
        send_req(MODE_DELETE, 8'd2,   32'h0,          1'b0);
        send_req(MODE_GET,    8'd1,   32'h0,          1'b0);
        send_req(MODE_INSERT, 8'd1,   32'h0,          1'b1);
        send_req(MODE_CLEAR,  8'd128, 32'h5A5A_5A5A,  1'b1);
        send_req(MODE_GET,    8'd0,   32'h0,          1'b0);

        // Random: fill to full, drain, mixed, refill, then a tail without gaps
        run_phase(200, 75, 10, 14);
        run_phase(200, 20, 55, 23);
        run_phase(150, 45, 35, 17);
        run_phase(150, 70, 15, 14);
        gaps_on = 1'b0;
        run_phase(100, 45, 35, 17);
        req_ch.valid <= 1'b0;

        // Drain outstanding responses, then idle before counting leftovers
        while (board.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        board.failures += board.pending_rsp.size();

        $display("requests: %0d insert, %0d delete, %0d get, %0d clear",
                 board.mode_seen[MODE_INSERT], board.mode_seen[MODE_DELETE],
                 board.mode_seen[MODE_GET], board.mode_seen[MODE_CLEAR]);
        $display("statuses: %0d ok, %0d zero handle, %0d full, %0d out of range; %0d errors",
                 board.status_seen[ST_OK], board.status_seen[ST_ZERO],
                 board.status_seen[ST_FULL], board.status_seen[ST_RANGE],
                 board.failures);
        if (board.failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
